FILE: sv/tlpc_pkg.sv
// Shared types, constants and codes for the tank level pump controller.
package tlpc_pkg;

   localparam int WINDOW_DEFAULT = 10;
   localparam int MM_PER_CM      = 10;

   localparam int KIND_W     = 3;
   localparam int MM_W       = 16;
   localparam int LEVEL_W    = 13;
   localparam int ERR_W      = 8;
   localparam int SEC_W      = 16;
   localparam int THRESH_W   = 8;
   localparam int ON_DELAY_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPORT       = 3'd0,
      KIND_TICK         = 3'd1,
      KIND_TIMEOUT      = 3'd2,
      KIND_AUTO         = 3'd3,
      KIND_MANUAL_START = 3'd4,
      KIND_MANUAL_STOP  = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_LEVEL       = 3'd0,
      CSR_OFF_LEVEL      = 3'd1,
      CSR_MAX_ERRORS     = 3'd2,
      CSR_ON_DELAY       = 3'd3,
      CSR_MANUAL_SECONDS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0]   on_level;
      logic [THRESH_W-1:0]   off_level;
      logic [ERR_W-1:0]      max_errors;
      logic [ON_DELAY_W-1:0] on_delay;
      logic [SEC_W-1:0]      manual_seconds;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      on_level:       8'd85,
      off_level:      8'd50,
      max_errors:     8'd6,
      on_delay:       6'd30,
      manual_seconds: 16'd600
   };

   typedef struct packed {
      logic            enable;
      logic [MM_W-1:0] level_mm;
   } report_type;

   typedef struct packed {
      logic [MM_W-1:0]    average;
      logic [LEVEL_W-1:0] level;
   } avg_result_type;

   typedef struct packed {
      logic               relay_on;
      logic [LEVEL_W-1:0] level_cm;
      logic               sensor_active;
      logic [ERR_W-1:0]   error_count;
      logic [SEC_W-1:0]   seconds_left;
      logic               auto_active;
   } status_type;

endpackage

FILE: sv/tlpc_ifs.sv
// Channel interfaces for events, results and register writes.
interface tlpc_req_if;
   import tlpc_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [MM_W-1:0]   level_mm;
   modport source (output valid, output kind, output level_mm, input ready);
   modport sink   (input valid, input kind, input level_mm, output ready);
endinterface

interface tlpc_rsp_if;
   import tlpc_pkg::*;
   logic               valid;
   logic               ready;
   logic               relay_on;
   logic [LEVEL_W-1:0] level_cm;
   logic [MM_W-1:0]    average_mm;
   logic               sensor_active;
   logic [ERR_W-1:0]   error_count;
   logic [SEC_W-1:0]   seconds_left;
   logic               auto_active;
   modport source (output valid, output relay_on, output level_cm, output average_mm,
                   output sensor_active, output error_count, output seconds_left,
                   output auto_active, input ready);
   modport sink   (input valid, input relay_on, input level_cm, input average_mm,
                   input sensor_active, input error_count, input seconds_left,
                   input auto_active, output ready);
endinterface

interface tlpc_csr_if;
   import tlpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/tank_level_pump_controller.sv
// Top level of the tank level pump controller.
// An accepted event waits in the stage register until the output is free.
// Throughput: one transaction per cycle when the output is free, set by the
// single update stage that writes the state registers (the result register).
// Reset: synchronous; clears the sample ring, the average, all status and the
// channel valid flags, and loads the default configuration.
module tank_level_pump_controller #(
   parameter int WINDOW = tlpc_pkg::WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tlpc_req_if.sink    req_bus,
   tlpc_rsp_if.source  rsp_bus,
   tlpc_csr_if.sink    csr_bus
);
   import tlpc_pkg::*;

   logic              stage_valid_ff, stage_valid_in;
   logic [KIND_W-1:0] stage_kind_ff;
   logic [MM_W-1:0]   stage_mm_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              fire;
   logic              req_take;

   cfg_type        cfg;
   report_type     report;
   avg_result_type avg;
   status_type     status;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = stage_valid_ff && out_free;
   assign req_bus.ready = !stage_valid_ff || fire;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign stage_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_kind_ff <= req_bus.kind;
         stage_mm_ff   <= req_bus.level_mm;
      end
   end

   tlpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tlpc_avg #(
      .WINDOW (WINDOW)
   ) u_avg (
      .clock  (clock),
      .reset  (reset),
      .report (report),
      .result (avg)
   );

   tlpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .kind     (stage_kind_ff),
      .level_mm (stage_mm_ff),
      .cfg      (cfg),
      .avg      (avg),
      .report   (report),
      .status   (status)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.relay_on      = status.relay_on;
   assign rsp_bus.level_cm      = status.level_cm;
   assign rsp_bus.average_mm    = avg.average;
   assign rsp_bus.sensor_active = status.sensor_active;
   assign rsp_bus.error_count   = status.error_count;
   assign rsp_bus.seconds_left  = status.seconds_left;
   assign rsp_bus.auto_active   = status.auto_active;

   stage_moves_to_output : assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid_ff && !$past(req_take)) || (rsp_valid_ff && stage_valid_ff)
               || rsp_valid_ff)
      else $error("A processed transaction did not reach the output.");

endmodule

FILE: sv/tlpc_csr.sv
// Configuration register file written through the register channel.
module tlpc_csr (
   input  logic              clock,
   input  logic              reset,
   tlpc_csr_if.sink          csr_bus,
   output tlpc_pkg::cfg_type cfg
);
   import tlpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_ON_LEVEL:       cfg_in.on_level       = csr_bus.data[THRESH_W-1:0];
            CSR_OFF_LEVEL:      cfg_in.off_level      = csr_bus.data[THRESH_W-1:0];
            CSR_MAX_ERRORS:     cfg_in.max_errors     = csr_bus.data[ERR_W-1:0];
            CSR_ON_DELAY:       cfg_in.on_delay       = csr_bus.data[ON_DELAY_W-1:0];
            CSR_MANUAL_SECONDS: cfg_in.manual_seconds = csr_bus.data[SEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/tlpc_avg.sv
// Sample ring, running total and moving average with constant reciprocal division.
module tlpc_avg #(
   parameter int WINDOW = tlpc_pkg::WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tlpc_pkg::report_type     report,
   output tlpc_pkg::avg_result_type result
);
   import tlpc_pkg::*;

   localparam int IDX_W       = $clog2(WINDOW);
   localparam int TOTAL_W     = MM_W + $clog2(WINDOW);
   localparam int RECIP_W     = TOTAL_W + 1;
   localparam int PROD_W      = TOTAL_W + RECIP_W;
   localparam int LEVEL_DIV   = WINDOW * MM_PER_CM;
   localparam int AVG_SHIFT   = TOTAL_W + $clog2(WINDOW);
   localparam int LEVEL_SHIFT = TOTAL_W + $clog2(LEVEL_DIV);
   localparam longint AVG_RECIP_L =
      ((longint'(1) << AVG_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam longint LEVEL_RECIP_L =
      ((longint'(1) << LEVEL_SHIFT) + longint'(LEVEL_DIV) - 1) / longint'(LEVEL_DIV);
   localparam logic [RECIP_W-1:0] AVG_RECIP   = RECIP_W'(AVG_RECIP_L);
   localparam logic [RECIP_W-1:0] LEVEL_RECIP = RECIP_W'(LEVEL_RECIP_L);

   logic [MM_W-1:0]    ring_ff [WINDOW];
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [MM_W-1:0]    avg_ff;
   logic [PROD_W-1:0]  avg_prod;
   logic [PROD_W-1:0]  level_prod;
   logic [MM_W-1:0]    avg_quot;
   logic [LEVEL_W-1:0] level_quot;

   assign total_in = total_ff - TOTAL_W'(ring_ff[idx_ff]) + TOTAL_W'(report.level_mm);
   assign idx_in   = (idx_ff == IDX_W'(WINDOW - 1)) ? '0 : idx_ff + IDX_W'(1);

   // Exact floor division: the reciprocals are rounded up with enough fraction bits
   // for every total the ring can hold.
   assign avg_prod   = PROD_W'(total_in) * PROD_W'(AVG_RECIP);
   assign level_prod = PROD_W'(total_in) * PROD_W'(LEVEL_RECIP);
   assign avg_quot   = avg_prod[AVG_SHIFT +: MM_W];
   assign level_quot = level_prod[LEVEL_SHIFT +: LEVEL_W];

   assign result.average = avg_ff;
   assign result.level   = level_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         idx_ff   <= '0;
         total_ff <= '0;
         avg_ff   <= '0;
      end else if (report.enable) begin
         ring_ff[idx_ff] <= report.level_mm;
         idx_ff          <= idx_in;
         total_ff        <= total_in;
         avg_ff          <= avg_quot;
      end
   end

   ring_index_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(WINDOW - 1))
      else $error("Ring index has left the window.");

   ring_index_moves : assert property (@(posedge clock) disable iff (reset)
      report.enable |=> idx_ff != $past(idx_ff))
      else $error("A stored report did not advance the ring index.");

endmodule

FILE: sv/tlpc_ctrl.sv
// Event decoding, sensor supervision, relay control and manual countdown.
module tlpc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [tlpc_pkg::KIND_W-1:0] kind,
   input  logic [tlpc_pkg::MM_W-1:0]   level_mm,
   input  tlpc_pkg::cfg_type           cfg,
   input  tlpc_pkg::avg_result_type    avg,
   output tlpc_pkg::report_type        report,
   output tlpc_pkg::status_type        status
);
   import tlpc_pkg::*;

   logic                  relay_ff, relay_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  alive_ff, alive_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic [SEC_W-1:0]      cd_ff, cd_in;
   logic                  auto_ff, auto_in;
   logic [ON_DELAY_W-1:0] qual_ff, qual_in;

   logic [ERR_W-1:0]      err_inc;
   logic [SEC_W-1:0]      cd_dec;
   logic [SEC_W:0]        cd_sum;
   logic [SEC_W-1:0]      cd_sat;
   logic [ON_DELAY_W:0]   qual_inc;
   logic                  tick_counts;

   assign err_inc  = (err_ff != '1) ? err_ff + ERR_W'(1) : err_ff;
   assign cd_dec   = (cd_ff != '0) ? cd_ff - SEC_W'(1) : cd_ff;
   assign cd_sum   = {1'b0, cd_ff} + {1'b0, cfg.manual_seconds};
   assign cd_sat   = cd_sum[SEC_W] ? '1 : cd_sum[SEC_W-1:0];
   assign qual_inc = {1'b0, qual_ff} + (ON_DELAY_W + 1)'(1);
   assign tick_counts = auto_ff && (level_ff >= LEVEL_W'(cfg.on_level)) && alive_ff &&
                        (level_ff != '0) && !relay_ff;

   assign report.enable   = fire && (kind_type'(kind) == KIND_REPORT) && (level_mm != '0);
   assign report.level_mm = level_mm;

   always_comb begin
      relay_in = relay_ff;
      level_in = level_ff;
      alive_in = alive_ff;
      err_in   = err_ff;
      cd_in    = cd_ff;
      auto_in  = auto_ff;
      qual_in  = qual_ff;
      if (fire) begin
         unique case (kind_type'(kind))
            KIND_REPORT: begin
               if (level_mm == '0) begin
                  err_in = err_inc;
               end else begin
                  err_in   = '0;
                  alive_in = 1'b1;
                  level_in = avg.level;
               end
            end
            KIND_TICK: begin
               cd_in = cd_dec;
               if (tick_counts) begin
                  if (qual_inc > {1'b0, cfg.on_delay}) begin
                     relay_in = 1'b1;
                     qual_in  = '0;
                  end else begin
                     qual_in = qual_inc[ON_DELAY_W-1:0];
                  end
               end
            end
            KIND_TIMEOUT: err_in = err_inc;
            KIND_AUTO: begin
               auto_in  = 1'b1;
               relay_in = 1'b0;
            end
            KIND_MANUAL_START: begin
               auto_in  = 1'b0;
               cd_in    = cd_sat;
               relay_in = 1'b1;
            end
            KIND_MANUAL_STOP: begin
               auto_in  = 1'b0;
               cd_in    = '0;
               relay_in = 1'b0;
            end
            default: ;
         endcase

         if (err_in >= cfg.max_errors) begin
            alive_in = 1'b0;
            level_in = '0;
         end

         if (auto_in) begin
            if ((level_in <= LEVEL_W'(cfg.off_level)) || !alive_in) begin
               qual_in  = '0;
               relay_in = 1'b0;
            end
         end else if ((cd_in == '0) && relay_in) begin
            qual_in  = '0;
            relay_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff <= 1'b0;
         level_ff <= '0;
         alive_ff <= 1'b0;
         err_ff   <= '0;
         cd_ff    <= '0;
         auto_ff  <= 1'b0;
         qual_ff  <= '0;
      end else begin
         relay_ff <= relay_in;
         level_ff <= level_in;
         alive_ff <= alive_in;
         err_ff   <= err_in;
         cd_ff    <= cd_in;
         auto_ff  <= auto_in;
         qual_ff  <= qual_in;
      end
   end

   assign status.relay_on      = relay_ff;
   assign status.level_cm      = level_ff;
   assign status.sensor_active = alive_ff;
   assign status.error_count   = err_ff;
   assign status.seconds_left  = cd_ff;
   assign status.auto_active   = auto_ff;

   auto_relay_needs_sensor : assert property (@(posedge clock) disable iff (reset)
      (auto_ff && relay_ff) |-> alive_ff)
      else $error("Relay on in automatic mode without a live sensor.");

   manual_relay_needs_time : assert property (@(posedge clock) disable iff (reset)
      (!auto_ff && relay_ff) |-> (cd_ff != '0))
      else $error("Relay on in manual mode with no time left.");

   dead_sensor_zero_level : assert property (@(posedge clock) disable iff (reset)
      !alive_ff |-> (level_ff == '0))
      else $error("Level is nonzero while the sensor is inactive.");

endmodule

FILE: bench/tank_level_pump_controller_tb.sv
// Self-checking testbench for the tank level pump controller: directed table, then random phases.
module tank_level_pump_controller_tb;
   import tlpc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_LOW  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HIGH = 3'd7;
   localparam int PHASE_ITEMS = 85;
   localparam int LONG_HOLD   = 200;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic               relay_on;
      logic [LEVEL_W-1:0] level_cm;
      logic [MM_W-1:0]    average_mm;
      logic               sensor_active;
      logic [ERR_W-1:0]   error_count;
      logic [SEC_W-1:0]   seconds_left;
      logic               auto_active;
   } pump_status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [MM_W-1:0]   mm;
      logic              typed;
      pump_status_type   want;
   } directed_row_type;

   logic clock;
   logic reset;

   tlpc_req_if req_bus ();
   tlpc_rsp_if rsp_bus ();
   tlpc_csr_if csr_bus ();

   tank_level_pump_controller DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state, kept at the widths of the block.
   cfg_type             model_cfg;
   logic [MM_W-1:0]     ring [16];
   logic [19:0]         total_mm;
   logic [3:0]          ring_pos;
   logic [MM_W-1:0]     avg_mm;
   logic [LEVEL_W-1:0]  lvl_cm;
   logic [ERR_W-1:0]    err_cnt;
   logic                alive;
   logic                relay;
   logic [ON_DELAY_W-1:0] qualify;
   logic [SEC_W-1:0]    secs;
   logic                auto_on;

   pump_status_type  pending_status [$];
   directed_row_type tabled_status [$];
   directed_row_type directed_rows [$];

   int unsigned events_sent    = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 34;
   int unsigned rcv_idle_pct   = 87;
   int unsigned stall_requests = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      model_cfg = CFG_RESET;
      foreach (ring[i]) ring[i] = '0;
      total_mm = '0;
      ring_pos = '0;
      avg_mm   = '0;
      lvl_cm   = '0;
      err_cnt  = '0;
      alive    = 1'b0;
      relay    = 1'b0;
      qualify  = '0;
      secs     = '0;
      auto_on  = 1'b0;
   end

   function automatic pump_status_type status_of(bit relay_bit, int level, int average,
                                                 bit active, int errors, int seconds,
                                                 bit auto_bit);
      pump_status_type s;
      s.relay_on      = relay_bit;
      s.level_cm      = LEVEL_W'(level);
      s.average_mm    = MM_W'(average);
      s.sensor_active = active;
      s.error_count   = ERR_W'(errors);
      s.seconds_left  = SEC_W'(seconds);
      s.auto_active   = auto_bit;
      return s;
   endfunction

   function automatic pump_status_type advance_pump(input logic [KIND_W-1:0] kind,
                                                    input logic [MM_W-1:0] mm);
      logic [SEC_W:0] sum;
      case (kind)
         KIND_REPORT: begin
            if (mm == '0) begin
               if (err_cnt != '1) err_cnt = err_cnt + 1'b1;
            end else begin
               err_cnt  = '0;
               alive    = 1'b1;
               total_mm = total_mm - ring[ring_pos] + mm;
               ring[ring_pos] = mm;
               ring_pos = (ring_pos == WINDOW_DEFAULT - 1) ? 4'd0 : ring_pos + 4'd1;
               avg_mm   = MM_W'(total_mm / WINDOW_DEFAULT);
               lvl_cm   = LEVEL_W'(avg_mm / MM_PER_CM);
            end
         end
         KIND_TICK: begin
            if (secs != '0) secs = secs - 1'b1;
            if (auto_on && lvl_cm >= model_cfg.on_level && alive && lvl_cm != '0 && !relay) begin
               if (int'(qualify) + 1 > int'(model_cfg.on_delay)) begin
                  relay   = 1'b1;
                  qualify = '0;
               end else begin
                  qualify = qualify + 1'b1;
               end
            end
         end
         KIND_TIMEOUT: begin
            if (err_cnt != '1) err_cnt = err_cnt + 1'b1;
         end
         KIND_AUTO: begin
            auto_on = 1'b1;
            relay   = 1'b0;
         end
         KIND_MANUAL_START: begin
            auto_on = 1'b0;
            sum     = {1'b0, secs} + {1'b0, model_cfg.manual_seconds};
            secs    = sum[SEC_W] ? '1 : sum[SEC_W-1:0];
            relay   = 1'b1;
         end
         KIND_MANUAL_STOP: begin
            auto_on = 1'b0;
            secs    = '0;
            relay   = 1'b0;
         end
         default: ;
      endcase
      if (err_cnt >= model_cfg.max_errors) begin
         alive  = 1'b0;
         lvl_cm = '0;
      end
      if (auto_on) begin
         if (lvl_cm <= model_cfg.off_level || !alive) begin
            qualify = '0;
            relay   = 1'b0;
         end
      end else if (secs == '0 && relay) begin
         qualify = '0;
         relay   = 1'b0;
      end
      return status_of(relay, lvl_cm, avg_mm, alive, err_cnt, secs, auto_on);
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: result %0d: %s is %0d, expected %0d", $time, results_seen, field,
                  got, want);
      mismatch_count++;
   endtask

   task automatic check_status(input pump_status_type got, input pump_status_type want);
      if (got.relay_on !== want.relay_on)
         report_mismatch("relay_on", 32'(got.relay_on), 32'(want.relay_on));
      if (got.level_cm !== want.level_cm)
         report_mismatch("level_cm", 32'(got.level_cm), 32'(want.level_cm));
      if (got.average_mm !== want.average_mm)
         report_mismatch("average_mm", 32'(got.average_mm), 32'(want.average_mm));
      if (got.sensor_active !== want.sensor_active)
         report_mismatch("sensor_active", 32'(got.sensor_active), 32'(want.sensor_active));
      if (got.error_count !== want.error_count)
         report_mismatch("error_count", 32'(got.error_count), 32'(want.error_count));
      if (got.seconds_left !== want.seconds_left)
         report_mismatch("seconds_left", 32'(got.seconds_left), 32'(want.seconds_left));
      if (got.auto_active !== want.auto_active)
         report_mismatch("auto_active", 32'(got.auto_active), 32'(want.auto_active));
   endtask

   always @(posedge clock) begin
      pump_status_type  got;
      pump_status_type  want;
      directed_row_type row;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.relay_on, rsp_bus.level_cm, rsp_bus.average_mm,
                   rsp_bus.sensor_active, rsp_bus.error_count, rsp_bus.seconds_left,
                   rsp_bus.auto_active};
            if (pending_status.size() == 0) begin
               report_mismatch("transaction with nothing outstanding", 1, 0);
            end else begin
               want = pending_status.pop_front();
               check_status(got, want);
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            want = advance_pump(req_bus.kind, req_bus.level_mm);
            if (tabled_status.size() != 0) begin
               row = tabled_status.pop_front();
               if (row.typed) want = row.want;
            end
            pending_status.push_back(want);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_ON_LEVEL:       model_cfg.on_level       = csr_bus.data[THRESH_W-1:0];
               CSR_OFF_LEVEL:      model_cfg.off_level      = csr_bus.data[THRESH_W-1:0];
               CSR_MAX_ERRORS:     model_cfg.max_errors     = csr_bus.data[ERR_W-1:0];
               CSR_ON_DELAY:       model_cfg.on_delay       = csr_bus.data[ON_DELAY_W-1:0];
               CSR_MANUAL_SECONDS: model_cfg.manual_seconds = csr_bus.data[SEC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // The receiver holds off for a long stretch whenever the stimulus asks for it.
   initial begin
      int unsigned stalls_done;
      int unsigned hold_left;
      stalls_done = 0;
      hold_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requests != stalls_done) begin
            stalls_done = stall_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   task automatic send_event(input logic [KIND_W-1:0] kind, input logic [MM_W-1:0] mm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.level_mm <= mm;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      events_sent++;
   endtask

   task automatic load_settings(input cfg_type c);
      csr_index_type    idx;
      logic [CSR_DATA_W-1:0] value;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_seen < events_sent);
      for (int i = 0; i < 5; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_ON_LEVEL:       value = CSR_DATA_W'(c.on_level);
            CSR_OFF_LEVEL:      value = CSR_DATA_W'(c.off_level);
            CSR_MAX_ERRORS:     value = CSR_DATA_W'(c.max_errors);
            CSR_ON_DELAY:       value = CSR_DATA_W'(c.on_delay);
            default:            value = c.manual_seconds;
         endcase
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data  <= value;
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
      end
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      cfg_type     c;
      int unsigned phase_start;
      int unsigned pick;
      int unsigned target_mm;
      bit          paused;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.kind     <= KIND_REPORT;
      req_bus.level_mm <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_ON_LEVEL;
      csr_bus.data     <= '0;

      directed_rows.push_back('{KIND_TICK, 16'd0, 1'b1, status_of(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{KIND_TIMEOUT, 16'd0, 1'b1, status_of(0, 0, 0, 0, 1, 0, 0)});
      directed_rows.push_back('{KIND_REPORT, 16'd0, 1'b1, status_of(0, 0, 0, 0, 2, 0, 0)});
      directed_rows.push_back('{KIND_REPORT, 16'hFFFF, 1'b1,
                                status_of(0, 655, 6553, 1, 0, 0, 0)});
      directed_rows.push_back('{KIND_MANUAL_START, 16'hFFFF, 1'b1,
                                status_of(1, 655, 6553, 1, 0, 600, 0)});
      directed_rows.push_back('{KIND_TICK, 16'd0, 1'b1, status_of(1, 655, 6553, 1, 0, 599, 0)});
      directed_rows.push_back('{KIND_SPARE_LOW, 16'd0, 1'b1,
                                status_of(1, 655, 6553, 1, 0, 599, 0)});
      directed_rows.push_back('{KIND_SPARE_HIGH, 16'hFFFF, 1'b1,
                                status_of(1, 655, 6553, 1, 0, 599, 0)});
      directed_rows.push_back('{KIND_MANUAL_STOP, 16'd0, 1'b1,
                                status_of(0, 655, 6553, 1, 0, 0, 0)});
      directed_rows.push_back('{KIND_AUTO, 16'd0, 1'b1, status_of(0, 655, 6553, 1, 0, 0, 1)});
      directed_rows.push_back('{KIND_TICK, 16'd0, 1'b1, status_of(0, 655, 6553, 1, 0, 0, 1)});
      directed_rows.push_back('{KIND_REPORT, 16'd1, 1'b0, '0});
      directed_rows.push_back('{KIND_REPORT, 16'h5555, 1'b0, '0});
      directed_rows.push_back('{KIND_REPORT, 16'hAAAA, 1'b0, '0});
      repeat (6) directed_rows.push_back('{KIND_TIMEOUT, 16'd0, 1'b0, '0});
      directed_rows.push_back('{KIND_TICK, 16'd0, 1'b0, '0});
      directed_rows.push_back('{KIND_REPORT, 16'd100, 1'b0, '0});
      directed_rows.push_back('{KIND_MANUAL_START, 16'd0, 1'b0, '0});
      directed_rows.push_back('{KIND_MANUAL_START, 16'd0, 1'b0, '0});
      directed_rows.push_back('{KIND_MANUAL_STOP, 16'd0, 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         tabled_status.push_back(directed_rows[i]);
         send_event(directed_rows[i].kind, directed_rows[i].mm);
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: c = '{8'd20, 8'd10, 8'd3, 6'd1, 16'd5};
            1: c = '{8'd255, 8'd255, 8'd255, 6'd63, 16'd65535};
            2: c = '{8'd0, 8'd0, 8'd1, 6'd1, 16'd1};
            3: c = '{8'd100, 8'd40, 8'd0, 6'd2, 16'd0};
            4: c = '{THRESH_W'($urandom_range(255)), THRESH_W'($urandom_range(255)),
                     ERR_W'($urandom_range(255)), ON_DELAY_W'($urandom_range(63)),
                     SEC_W'($urandom_range(65535))};
            default: c = CFG_RESET;
         endcase
         send_idle_pct = (p < 2) ? 34 : (p < 4) ? 87 : 0;
         rcv_idle_pct  = (p < 2) ? 87 : (p < 4) ? 34 : 0;
         load_settings(c);
         if (p == 2) stall_requests++;
         if (p == 1) repeat (260) send_event(KIND_TIMEOUT, 16'd0);
         phase_start = events_sent;
         paused      = 1'b0;
         while (events_sent - phase_start < PHASE_ITEMS) begin
            if (p == 4 && !paused && events_sent - phase_start >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               req_bus.valid <= 1'b0;
               do @(posedge clock); while (results_seen < events_sent);
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
               target_mm = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                    : $urandom_range(2900);
               repeat ($urandom_range(WINDOW_DEFAULT + 2, 3))
                  send_event(KIND_REPORT, MM_W'(target_mm + $urandom_range(15)));
               if ($urandom_range(4) != 0) send_event(KIND_AUTO, MM_W'($urandom));
               repeat ($urandom_range(model_cfg.on_delay + 3)) begin
                  if ($urandom_range(7) == 0)
                     send_event(KIND_REPORT, MM_W'(target_mm + $urandom_range(15)));
                  else
                     send_event(KIND_TICK, MM_W'($urandom));
               end
            end else if (pick < 60) begin
               repeat ($urandom_range(2, 1)) send_event(KIND_MANUAL_START, MM_W'($urandom));
               repeat ($urandom_range(6)) send_event(KIND_TICK, MM_W'($urandom));
               if ($urandom_range(1) != 0) send_event(KIND_MANUAL_STOP, MM_W'($urandom));
            end else if (pick < 75) begin
               repeat ($urandom_range(12, 1))
                  send_event(($urandom_range(1) != 0) ? KIND_TIMEOUT : KIND_REPORT, 16'd0);
            end else begin
               repeat ($urandom_range(6, 1))
                  send_event(KIND_W'($urandom_range(2 ** KIND_W - 1)),
                             ($urandom_range(1) != 0) ? MM_W'($urandom)
                                                      : MM_W'($urandom_range(3000)));
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (results_seen < events_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_status.size() != 0)
         report_mismatch("transactions still outstanding", pending_status.size(), 0);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: tank_level_pump_controller.f
sv/tlpc_pkg.sv
sv/tlpc_ifs.sv
sv/tlpc_csr.sv
sv/tlpc_avg.sv
sv/tlpc_ctrl.sv
sv/tank_level_pump_controller.sv
bench/tank_level_pump_controller_tb.sv
